@@ rtl/bevel_rect_pixel_painter_top_defines.svh @@
// assertion macros for the bevel rectangle pixel painter
`ifndef BEVEL_RECT_PIXEL_PAINTER_TOP_DEFINES_SVH
`define BEVEL_RECT_PIXEL_PAINTER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define BRPP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("brpp assertion failed");

// next-cycle implication, sampled on clk, off while in reset
`define BRPP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("brpp assertion failed");

`endif

@@ rtl/brpp_pkg.sv @@
// shared types and constants for the bevel rectangle pixel painter
package brpp_pkg;

	localparam int COORD_BITS = 12;
	localparam int PIXEL_BITS = 32;
	localparam int ADDR_BITS  = 24;
	// signed width for band bounds: 13-bit bound plus 12-bit edge, no wrap
	localparam int SEXT_BITS  = COORD_BITS + 3;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_ROW_STRIDE  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_RECT_LEFT   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_RECT_TOP    = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_RECT_RIGHT  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_RECT_BOTTOM = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_WIDTH  = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_FORE_COLOR  = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_BACK_COLOR  = 3'd7;

	localparam logic [COORD_BITS:0] ROW_STRIDE_RESET = 13'd4096;

	// request modes
	localparam logic MODE_FILL  = 1'b0;
	localparam logic MODE_BEVEL = 1'b1;

	typedef struct packed {
		logic                  req_type;
		logic [COORD_BITS-1:0] pix_x;
		logic [COORD_BITS-1:0] pix_y;
	} req_t;

	typedef struct packed {
		logic                  write_enable;
		logic [ADDR_BITS-1:0]  frame_address;
		logic [PIXEL_BITS-1:0] pixel_color;
	} rsp_t;

	typedef struct packed {
		logic [COORD_BITS:0]   row_stride;
		logic [COORD_BITS:0]   rect_left;
		logic [COORD_BITS:0]   rect_top;
		logic [COORD_BITS:0]   rect_right;
		logic [COORD_BITS:0]   rect_bottom;
		logic [COORD_BITS-1:0] edge_width;
		logic [PIXEL_BITS-1:0] fore_color;
		logic [PIXEL_BITS-1:0] back_color;
	} cfg_t;

endpackage

@@ rtl/bevel_rect_pixel_painter_top.sv @@
// top level: config registers, input register, classifier and result register
// an accepted transaction passes through the input register, then its result through the result register
// throughput: one pixel per clock while rsp_ready is not held low, set by the input and result registers
// the single multiply and band compares sit between the two registers
// reset clears both valid flags and loads the register reset values
// (row stride 4096, everything else zero)
`include "bevel_rect_pixel_painter_top_defines.svh"

module bevel_rect_pixel_painter_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  brpp_pkg::req_t                      req,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output brpp_pkg::rsp_t                      rsp,
	input  logic                                cfg_we,
	input  logic [brpp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [brpp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int CB = brpp_pkg::COORD_BITS;
	localparam int PB = brpp_pkg::PIXEL_BITS;

	brpp_pkg::cfg_t cfg_q;
	brpp_pkg::req_t req_s1;
	brpp_pkg::rsp_t rsp_next;
	brpp_pkg::rsp_t rsp_s2;
	logic v_s1;
	logic v_s2;
	logic adv;
	logic req_fire;

	// configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_stride  <= brpp_pkg::ROW_STRIDE_RESET;
			cfg_q.rect_left   <= '0;
			cfg_q.rect_top    <= '0;
			cfg_q.rect_right  <= '0;
			cfg_q.rect_bottom <= '0;
			cfg_q.edge_width  <= '0;
			cfg_q.fore_color  <= '0;
			cfg_q.back_color  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				brpp_pkg::REG_ROW_STRIDE:  cfg_q.row_stride  <= cfg_data[CB:0];
				brpp_pkg::REG_RECT_LEFT:   cfg_q.rect_left   <= cfg_data[CB:0];
				brpp_pkg::REG_RECT_TOP:    cfg_q.rect_top    <= cfg_data[CB:0];
				brpp_pkg::REG_RECT_RIGHT:  cfg_q.rect_right  <= cfg_data[CB:0];
				brpp_pkg::REG_RECT_BOTTOM: cfg_q.rect_bottom <= cfg_data[CB:0];
				brpp_pkg::REG_EDGE_WIDTH:  cfg_q.edge_width  <= cfg_data[CB-1:0];
				brpp_pkg::REG_FORE_COLOR:  cfg_q.fore_color  <= cfg_data[PB-1:0];
				brpp_pkg::REG_BACK_COLOR:  cfg_q.back_color  <= cfg_data[PB-1:0];
			endcase
		end
	end

	// pipeline moves whenever the result slot is free or being taken
	assign adv       = !v_s2 || rsp_ready;
	assign req_ready = adv || !v_s1;
	assign req_fire  = req_valid && req_ready;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (req_ready) begin
				v_s1 <= req_valid;
			end
			if (adv) begin
				v_s2 <= v_s1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_s1 <= req;
		end
		if (adv && v_s1) begin
			rsp_s2 <= rsp_next;
		end
	end

	brpp_classify u_classify (
		.req (req_s1),
		.cfg (cfg_q),
		.rsp (rsp_next)
	);

	assign rsp_valid = v_s2;
	assign rsp       = rsp_s2;

	// checks
	`BRPP_ASSERT_NEXT(a_accept_fills_s1, req_fire, v_s1)
	`BRPP_ASSERT_NEXT(a_s1_moves_to_empty_out, v_s1 && !v_s2, v_s2)
	`BRPP_ASSERT_NOW(a_stall_only_when_full, !req_ready, v_s1 && v_s2)
	`BRPP_ASSERT_NOW(a_unpainted_black, v_s2 && !rsp_s2.write_enable, rsp_s2.pixel_color == '0)

endmodule

@@ rtl/brpp_classify.sv @@
// per-pixel region classification, colour pick and frame address
module brpp_classify (
	input  brpp_pkg::req_t req,
	input  brpp_pkg::cfg_t cfg,
	output brpp_pkg::rsp_t rsp
);

	localparam int SW = brpp_pkg::SEXT_BITS;

	logic signed [SW-1:0] x, y, l, t, r, b, e;
	logic signed [SW-1:0] le, te, re, be;
	logic signed [SW-1:0] tdx, tdy, bdx, bdy;
	logic left_hit, top_hit, right_hit, bottom_hit;
	logic tr_hit, bl_hit, tr_wins, use_tr, use_bl;
	logic tr_fore, bl_fore;
	logic fill_hit;
	logic [2*brpp_pkg::COORD_BITS:0] row_offset;
	logic [brpp_pkg::ADDR_BITS-1:0] addr_sum;

	function automatic logic in_box(
		input logic signed [SW-1:0] px, input logic signed [SW-1:0] py,
		input logic signed [SW-1:0] bl, input logic signed [SW-1:0] bt,
		input logic signed [SW-1:0] br, input logic signed [SW-1:0] bb
	);
		in_box = (px >= bl) && (px < br) && (py >= bt) && (py < bb);
	endfunction

	// widen everything to signed so bounds never wrap
	assign x = $signed({3'b000, req.pix_x});
	assign y = $signed({3'b000, req.pix_y});
	assign l = $signed({2'b00, cfg.rect_left});
	assign t = $signed({2'b00, cfg.rect_top});
	assign r = $signed({2'b00, cfg.rect_right});
	assign b = $signed({2'b00, cfg.rect_bottom});
	assign e = $signed({3'b000, cfg.edge_width});

	assign le = l + e;
	assign te = t + e;
	assign re = r - e;
	assign be = b - e;

	// band membership
	assign fill_hit   = in_box(x, y, l, t, r, b);
	assign left_hit   = in_box(x, y, l, t, le, be);
	assign top_hit    = in_box(x, y, le, t, re, te);
	assign right_hit  = in_box(x, y, re, te, r, b);
	assign bottom_hit = in_box(x, y, le, be, re, b);

	// corner squares and their offsets
	assign tdx = x - re;
	assign tdy = y - t;
	assign bdx = x - l;
	assign bdy = y - be;
	assign tr_hit = in_box(x, y, re, t, r, te);
	assign bl_hit = in_box(x, y, l, be, le, b);

	// overlapping corners: the later raster-order offset within its corner wins, bottom-left on a tie
	assign tr_wins = (tdy > bdy) || ((tdy == bdy) && (tdx > bdx));
	assign use_tr  = tr_hit && (!bl_hit || tr_wins);
	assign use_bl  = bl_hit && (!tr_hit || !tr_wins);

	// diagonal split inside each corner
	assign tr_fore = (tdx + tdy) < e;
	assign bl_fore = (bdx + bdy) < e;

	// linear address, wraps at the address width
	assign row_offset = req.pix_y * cfg.row_stride;
	assign addr_sum = row_offset[brpp_pkg::ADDR_BITS-1:0]
		+ {{(brpp_pkg::ADDR_BITS-brpp_pkg::COORD_BITS){1'b0}}, req.pix_x};

	// fill mode: fore colour inside the box; bevel priority: corners, bottom and right, top and left
	always_comb begin
		rsp.write_enable  = 1'b0;
		rsp.pixel_color   = '0;
		rsp.frame_address = addr_sum;
		if (req.req_type == brpp_pkg::MODE_FILL) begin
			if (fill_hit) begin
				rsp.write_enable = 1'b1;
				rsp.pixel_color  = cfg.fore_color;
			end
		end else if (use_bl) begin
			rsp.write_enable = 1'b1;
			rsp.pixel_color  = bl_fore ? cfg.fore_color : cfg.back_color;
		end else if (use_tr) begin
			rsp.write_enable = 1'b1;
			rsp.pixel_color  = tr_fore ? cfg.fore_color : cfg.back_color;
		end else if (bottom_hit || right_hit) begin
			rsp.write_enable = 1'b1;
			rsp.pixel_color  = cfg.back_color;
		end else if (top_hit || left_hit) begin
			rsp.write_enable = 1'b1;
			rsp.pixel_color  = cfg.fore_color;
		end
	end

endmodule
